[rtl/core/block_diagonal_matmul_core_assert.svh]
// assertion macros shared by the block diagonal multiply rtl
`ifndef BLOCK_DIAGONAL_MATMUL_CORE_ASSERT_SVH
`define BLOCK_DIAGONAL_MATMUL_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BDM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BDM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bdm_pkg.sv]
// shared constants, types and helpers of the block diagonal multiply core
package bdm_pkg;

   // sizes of the coefficient matrix
   localparam int MAX_BLOCK_IN  = 16;
   localparam int MAX_BLOCK_OUT = 16;
   localparam int ROW_ADDR_W    = $clog2(MAX_BLOCK_IN);

   // field widths
   localparam int VALUE_W   = 32;
   localparam int ROW_W     = 4;
   localparam int COL_W     = 4;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 4;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int ACC_W     = PROD_W - FRAC_W;

   // result queue: two banks of one block each
   localparam int OUTQ_BANKS = 2;
   localparam int BANK_W     = $clog2(OUTQ_BANKS);
   localparam int FULL_W     = $clog2(OUTQ_BANKS + 1);

   // command codes
   localparam logic CMD_COEFF = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_IN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_OUT = CSR_IDX_W'(1);

   // arithmetic limits
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
   localparam logic [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
   localparam logic [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
   localparam logic [VALUE_W-1:0] RES_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
   localparam logic [VALUE_W-1:0] RES_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

   // one block of results, one word per lane
   typedef logic [MAX_BLOCK_OUT-1:0][VALUE_W-1:0] result_row_type;

   // controls shared by all lanes
   typedef struct packed {
      logic                  advance;
      logic [ROW_ADDR_W-1:0] rd_row;
      logic [ROW_ADDR_W-1:0] wr_row;
      logic [VALUE_W-1:0]    wr_data;
      logic [VALUE_W-1:0]    mul_value;
      logic                  acc_en;
      logic                  acc_last;
      logic                  acc_clear;
   } lane_ctl_type;

   // controls of the result queue
   typedef struct packed {
      logic             load;
      logic [COL_W-1:0] last_col;
   } outq_ctl_type;

   // block size as used: zero acts as one, large values clamp to the maximum
   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] raw,
                                                 input logic [CFG_W-1:0] maxv);
      logic [CFG_W-1:0] res;
      if (raw == '0) begin
         res = CFG_W'(1);
      end else if (raw > maxv) begin
         res = maxv;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

[rtl/core/bdm_if.sv]
// valid/ready channels of the block diagonal multiply core

// input items: coefficient writes and data elements
interface bdm_req_if;
   import bdm_pkg::*;
   logic               valid;
   logic               ready;
   logic               command;
   logic [ROW_W-1:0]   coeff_row;
   logic [COL_W-1:0]   coeff_col;
   logic [VALUE_W-1:0] value;

   modport source (output valid, command, coeff_row, coeff_col, value, input ready);
   modport sink   (input valid, command, coeff_row, coeff_col, value, output ready);
endinterface

// result items
interface bdm_rsp_if;
   import bdm_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] result;
   logic [COL_W-1:0]   out_column;
   logic               last;

   modport source (output valid, result, out_column, last, input ready);
   modport sink   (input valid, result, out_column, last, output ready);
endinterface

// register writes
interface bdm_csr_if;
   import bdm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[rtl/core/bdm_lane.sv]
// one output column: coefficient column store, multiplier and accumulator
module bdm_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  bdm_pkg::lane_ctl_type      ctl,
   input  logic                       coeff_we,
   output logic [bdm_pkg::VALUE_W-1:0] result
);
   import bdm_pkg::*;

   logic [VALUE_W-1:0]        coeff_mem [MAX_BLOCK_IN];
   logic signed [VALUE_W-1:0] coeff_rd_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  rnd_full;
   logic signed [ACC_W-1:0]   rounded;
   logic signed [ACC_W:0]     acc_sum;
   logic [ACC_W-1:0]          acc_sat;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          acc_in;
   logic [ACC_W-VALUE_W:0]    acc_top;

   // column store, written by coefficient items
   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[ctl.wr_row] <= ctl.wr_data;
      end
   end

   // registered read of the row for the current block position
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         coeff_rd_ff <= $signed(coeff_mem[ctl.rd_row]);
      end
   end

   // full q32.32 product
   assign prod_in = $signed(ctl.mul_value) * coeff_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff <= prod_in;
      end
   end

   // round half up to 16 fraction bits, q32.16 in 48 bits
   assign rnd_full = prod_ff + ROUND_HALF;
   assign rounded  = rnd_full[PROD_W-1:FRAC_W];

   // saturating 48 bit accumulate
   always_comb begin
      acc_sum = $signed({acc_ff[ACC_W-1], acc_ff}) + $signed({rounded[ACC_W-1], rounded});
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
   end

   // result clamped to 32 bits
   assign acc_top = acc_sat[ACC_W-1:VALUE_W-1];
   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         result = acc_sat[VALUE_W-1:0];
      end else begin
         result = acc_sat[ACC_W-1] ? RES_MIN : RES_MAX;
      end
   end

   // accumulator restarts from zero after a block end or a block size write
   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = ctl.acc_last ? '0 : acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[rtl/core/bdm_outq.sv]
// two-bank result queue that sends one block of results one item at a time
`include "block_diagonal_matmul_core_assert.svh"

module bdm_outq (
   input  logic                    clock,
   input  logic                    reset,
   input  bdm_pkg::outq_ctl_type   ctl,
   input  bdm_pkg::result_row_type load_data,
   output logic                    space,
   bdm_rsp_if.source               rsp_ch
);
   import bdm_pkg::*;

   result_row_type     bank_ff [OUTQ_BANKS];
   logic [BANK_W-1:0]  wr_bank_ff;
   logic [BANK_W-1:0]  rd_bank_ff;
   logic [FULL_W-1:0]  full_ff;
   logic [FULL_W-1:0]  full_in;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic               pop;
   logic               pop_last;

   // output side
   assign rsp_ch.valid      = (full_ff != '0);
   assign rsp_ch.result     = bank_ff[rd_bank_ff][col_ff];
   assign rsp_ch.out_column = col_ff;
   assign rsp_ch.last       = (col_ff == ctl.last_col);

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign pop_last = pop && rsp_ch.last;
   assign space    = (full_ff != FULL_W'(OUTQ_BANKS));

   // fill count and column walk
   always_comb begin
      full_in = full_ff + FULL_W'(ctl.load) - FULL_W'(pop_last);
      col_in  = col_ff;
      if (pop_last) begin
         col_in = '0;
      end else if (pop) begin
         col_in = col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff    <= '0;
         col_ff     <= '0;
         wr_bank_ff <= '0;
         rd_bank_ff <= '0;
      end else begin
         full_ff <= full_in;
         col_ff  <= col_in;
         if (ctl.load) begin
            wr_bank_ff <= wr_bank_ff + BANK_W'(1);
         end
         if (pop_last) begin
            rd_bank_ff <= rd_bank_ff + BANK_W'(1);
         end
      end
   end

   // bank capture of a whole block
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         bank_ff[wr_bank_ff] <= load_data;
      end
   end

   // a block is never loaded into a full queue
   `BDM_ASSERT_IMP(a_no_load_when_full, clock, reset, ctl.load, space, "load into full queue")
   // a taken result that is not the last leaves the next one waiting
   `BDM_ASSERT_NXT(a_burst_continues, clock, reset, pop && !rsp_ch.last,
      rsp_ch.valid && (col_ff == $past(col_ff) + COL_W'(1)), "result burst broken")
   // fill count stays within the banks
   `BDM_ASSERT_IMP(a_full_bound, clock, reset, 1'b1, full_ff <= FULL_W'(OUTQ_BANKS),
      "queue fill count overrun")

endmodule

[rtl/core/block_diagonal_matmul_core.sv]
// top level of the block diagonal matrix multiply core
//
//   channel   dir  handshake      payload
//   req_ch    in   valid/ready    command, coeff_row, coeff_col, value
//   rsp_ch    out  valid/ready    result, out_column, last
//   csr_ch    in   valid/ready    index, wdata (block_in = 0, block_out = 1)
//
// one item per cycle unless stalled: all 16 lanes multiply-accumulate each data item in parallel.
// the item that ends a block passes stages s1 and s2, then its block_out results are loaded into
// a two-bank result queue and sent one per cycle while rsp_ch is ready.
// input stalls only while a block end waits on both queue banks being full.
// reset clears block sizes to 1, accumulators and position; the coefficient store is not cleared.
`include "block_diagonal_matmul_core_assert.svh"

module block_diagonal_matmul_core (
   input  logic      clock,
   input  logic      reset,
   bdm_req_if.sink   req_ch,
   bdm_rsp_if.source rsp_ch,
   bdm_csr_if.sink   csr_ch
);
   import bdm_pkg::*;

   logic [CFG_W-1:0]      block_in_ff;
   logic [CFG_W-1:0]      block_out_ff;
   logic [ROW_ADDR_W-1:0] pos_ff;
   logic [ROW_ADDR_W-1:0] pos_in;
   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic [VALUE_W-1:0]    s1_value_ff;
   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic                  advance;
   logic                  accept;
   logic                  data_acc;
   logic                  s0_last;
   logic                  csr_wr;
   logic                  csr_clear;
   logic                  space;
   logic [MAX_BLOCK_OUT-1:0] lane_we;
   lane_ctl_type          lane_ctl;
   outq_ctl_type          outq_ctl;
   result_row_type        row_data;

   // pipeline moves unless a block end finds the queue full
   assign advance      = !(s2_valid_ff && s2_last_ff && !space);
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign data_acc     = accept && (req_ch.command == CMD_DATA);
   assign s0_last      = ((CFG_W'(pos_ff) + CFG_W'(1)) == block_in_ff);

   // register writes
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;
   assign csr_clear    = csr_wr && ((csr_ch.index == CSR_BLOCK_IN) ||
                                    (csr_ch.index == CSR_BLOCK_OUT));

   always_ff @(posedge clock) begin
      if (reset) begin
         block_in_ff  <= CFG_W'(1);
         block_out_ff <= CFG_W'(1);
      end else if (csr_wr) begin
         case (csr_ch.index)
            CSR_BLOCK_IN: begin
               block_in_ff <= eff_size(csr_ch.wdata, CFG_W'(MAX_BLOCK_IN));
            end
            CSR_BLOCK_OUT: begin
               block_out_ff <= eff_size(csr_ch.wdata, CFG_W'(MAX_BLOCK_OUT));
            end
            default: begin
            end
         endcase
      end
   end

   // block position
   always_comb begin
      pos_in = pos_ff;
      if (csr_clear) begin
         pos_in = '0;
      end else if (data_acc) begin
         pos_in = s0_last ? '0 : pos_ff + ROW_ADDR_W'(1);
      end
   end

   // stage valids and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (advance) begin
            s1_valid_ff <= data_acc;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff  <= s0_last;
         s1_value_ff <= req_ch.value;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // coefficient write enables, one per column
   always_comb begin
      for (int c = 0; c < MAX_BLOCK_OUT; c++) begin
         lane_we[c] = accept && (req_ch.command == CMD_COEFF) &&
                      (int'(req_ch.coeff_row) < MAX_BLOCK_IN) &&
                      (int'(req_ch.coeff_col) == c);
      end
   end

   // lane controls
   always_comb begin
      lane_ctl.advance   = advance;
      lane_ctl.rd_row    = pos_ff;
      lane_ctl.wr_row    = ROW_ADDR_W'(req_ch.coeff_row);
      lane_ctl.wr_data   = req_ch.value;
      lane_ctl.mul_value = s1_value_ff;
      lane_ctl.acc_en    = s2_valid_ff && advance;
      lane_ctl.acc_last  = s2_last_ff;
      lane_ctl.acc_clear = csr_clear;
   end

   for (genvar c = 0; c < MAX_BLOCK_OUT; c++) begin : g_lane
      bdm_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .coeff_we (lane_we[c]),
         .result   (row_data[c])
      );
   end

   // result queue
   always_comb begin
      outq_ctl.load     = s2_valid_ff && s2_last_ff && advance;
      outq_ctl.last_col = COL_W'(block_out_ff - CFG_W'(1));
   end

   bdm_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .ctl       (outq_ctl),
      .load_data (row_data),
      .space     (space),
      .rsp_ch    (rsp_ch)
   );

   // results never name a column beyond the block
   `BDM_ASSERT_IMP(a_col_in_block, clock, reset, rsp_ch.valid,
      rsp_ch.out_column <= outq_ctl.last_col, "result column beyond block")
   // a block end waiting on the queue is held, not dropped
   `BDM_ASSERT_NXT(a_stall_holds, clock, reset, s2_valid_ff && s2_last_ff && !advance,
      s2_valid_ff && s2_last_ff, "stalled block end lost")
   // the item that ends a block restarts the position
   `BDM_ASSERT_NXT(a_pos_restart, clock, reset, data_acc && s0_last, pos_ff == '0,
      "block position not restarted")

endmodule

[dv/tb_block_diagonal_matmul_core.sv]
`timescale 1ns / 100ps
// block diagonal multiply testbench: coefficient preload, directed table, random items

module tb_block_diagonal_matmul_core;
   import bdm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int SETTLE_END   = 20;

   // register indexes that the core ignores
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(15);

   // handy Q16.16 values
   localparam logic [VALUE_W-1:0] Q_ONE       = 32'h0001_0000;
   localparam logic [VALUE_W-1:0] Q_HALF      = 32'h0000_8000;
   localparam logic [VALUE_W-1:0] Q_LSB       = 32'h0000_0001;
   localparam logic [VALUE_W-1:0] Q_MINUS_LSB = 32'hFFFF_FFFF;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type         kind;
      logic                 command;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
      logic [VALUE_W-1:0]   value;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     wdata;
      logic                 typed;
      logic [VALUE_W-1:0]   want;
   } stim_row_type;

   // one output element as the core should give it
   typedef struct packed {
      logic [VALUE_W-1:0] result;
      logic [COL_W-1:0]   column;
      logic               last;
   } col_result_type;

   logic clock = 1'b0;
   logic reset;

   bdm_req_if req_ch();
   bdm_rsp_if rsp_ch();
   bdm_csr_if csr_ch();

   block_diagonal_matmul_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // predictor state
   logic signed [VALUE_W-1:0] coeff_mem [MAX_BLOCK_IN][MAX_BLOCK_OUT];
   logic signed [ACC_W-1:0]   lane_acc [MAX_BLOCK_OUT];
   int unsigned               blk_pos;
   logic [CFG_W-1:0]          blk_in_reg;
   logic [CFG_W-1:0]          blk_out_reg;
   col_result_type            col_results_q[$];

   int err_count    = 0;
   int cycle_count  = 0;
   int hold_seq     = 0;
   int random_items = 0;
   stim_row_type directed_rows[$];

   // block size in use: zero acts as one, above the maximum clamps
   function automatic int unsigned clamp_size(logic [CFG_W-1:0] raw, int unsigned maxv);
      if (raw == '0) return 1;
      if (raw > maxv) return maxv;
      return 32'(raw);
   endfunction

   // Q16.16 product, rounded half up
   function automatic logic signed [ACC_W-1:0] q16_mul(logic signed [VALUE_W-1:0] a,
                                                       logic signed [VALUE_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = a * b;
      p = (p + 64'sd32768) >>> FRAC_W;
      return p[ACC_W-1:0];
   endfunction

   // 48-bit saturating add
   function automatic logic signed [ACC_W-1:0] add_sat48(logic signed [ACC_W-1:0] a,
                                                         logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = a + b;
      if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
      return s[ACC_W-1:0];
   endfunction

   // accumulator to a 32-bit result, saturated
   function automatic logic [VALUE_W-1:0] sat_result(logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:VALUE_W-1] == '0 || v[ACC_W-1:VALUE_W-1] == '1) return v[VALUE_W-1:0];
      return v[ACC_W-1] ? RES_MIN : RES_MAX;
   endfunction

   task automatic clear_block();
      foreach (lane_acc[c]) lane_acc[c] = '0;
      blk_pos = 0;
   endtask

   // advance the predictor by one accepted item, queue the block results it ends
   task automatic accumulate_item(logic command, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                  logic signed [VALUE_W-1:0] value, bit keep);
      int unsigned bi;
      int unsigned bo;
      col_result_type r;
      bi = clamp_size(blk_in_reg, MAX_BLOCK_IN);
      bo = clamp_size(blk_out_reg, MAX_BLOCK_OUT);
      if (command == CMD_COEFF) begin
         coeff_mem[row][col] = value;
         return;
      end
      for (int c = 0; c < bo; c++) begin
         lane_acc[c] = add_sat48(lane_acc[c], q16_mul(value, coeff_mem[blk_pos][c]));
      end
      blk_pos++;
      if (blk_pos < bi) return;
      for (int c = 0; c < bo; c++) begin
         r.result = sat_result(lane_acc[c]);
         r.column = COL_W'(c);
         r.last   = (c + 1 == bo);
         if (keep) col_results_q.push_back(r);
      end
      clear_block();
   endtask

   // random element value, biased toward the extremes
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = RES_MAX;
         1: v = RES_MIN;
         2: v = '0;
         3: v = Q_MINUS_LSB;
         4: v = VALUE_W'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh2_0000);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // random register value for a block size
   function automatic logic [CFG_W-1:0] pick_size();
      logic [CFG_W-1:0] s;
      case ($urandom_range(0, 11))
         0: s = '0;
         1: s = '1;
         2: s = CFG_W'(MAX_BLOCK_IN);
         3: s = CFG_W'($urandom_range(17, 30));
         4: s = CFG_W'($urandom_range(5, 15));
         default: s = CFG_W'($urandom_range(1, 4));
      endcase
      return s;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one item and wait for it to be taken; valid stays up
   task automatic send_item(logic command, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [VALUE_W-1:0] value, bit keep);
      req_ch.valid     <= 1'b1;
      req_ch.command   <= command;
      req_ch.coeff_row <= row;
      req_ch.coeff_col <= col;
      req_ch.value     <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      accumulate_item(command, row, col, value, keep);
   endtask

   task automatic idle_gap(bit burst);
      int n;
      n = pick_gap(burst);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop offering and let every expected result come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (col_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only with the core idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] wdata);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= wdata;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (index == CSR_BLOCK_IN) begin
         blk_in_reg = wdata;
         clear_block();
      end else if (index == CSR_BLOCK_OUT) begin
         blk_out_reg = wdata;
         clear_block();
      end
   endtask

   // directed table rows
   function automatic stim_row_type mk_coeff(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                             logic [VALUE_W-1:0] value);
      stim_row_type s;
      s = '0;
      s.kind    = ROW_ITEM;
      s.command = CMD_COEFF;
      s.row     = row;
      s.col     = col;
      s.value   = value;
      return s;
   endfunction

   function automatic stim_row_type mk_data(logic [VALUE_W-1:0] value);
      stim_row_type s;
      s = '0;
      s.kind    = ROW_ITEM;
      s.command = CMD_DATA;
      s.value   = value;
      return s;
   endfunction

   function automatic stim_row_type mk_data_typed(logic [VALUE_W-1:0] value,
                                                  logic [VALUE_W-1:0] want);
      stim_row_type s;
      s = mk_data(value);
      s.typed = 1'b1;
      s.want  = want;
      return s;
   endfunction

   function automatic stim_row_type mk_csr(logic [CSR_IDX_W-1:0] index,
                                           logic [CFG_W-1:0] wdata);
      stim_row_type s;
      s = '0;
      s.kind  = ROW_CSR;
      s.index = index;
      s.wdata = wdata;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      $display("%0t: mismatch on %s, got %h expected %h", $time, what, got, want);
      err_count++;
   endtask

   // compare one accepted result with the oldest expectation
   task automatic check_result();
      col_result_type want;
      if (col_results_q.size() == 0) begin
         report_mismatch("result with none expected", rsp_ch.result, 'x);
      end else begin
         want = col_results_q.pop_front();
         if (rsp_ch.result !== want.result) report_mismatch("result", rsp_ch.result, want.result);
         if (rsp_ch.out_column !== want.column) begin
            report_mismatch("out_column", VALUE_W'(rsp_ch.out_column), VALUE_W'(want.column));
         end
         if (rsp_ch.last !== want.last) begin
            report_mismatch("last", VALUE_W'(rsp_ch.last), VALUE_W'(want.last));
         end
      end
   endtask

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_block_diagonal_matmul_core: done, errors");
         $finish;
      end
   end

   // result side: check accepted items, random back-pressure, one long hold on request
   initial begin
      int stall_left;
      int steady_left;
      int hold_seen;
      int r;
      stall_left  = 0;
      steady_left = 0;
      hold_seen   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
         if (hold_seq != hold_seen) begin
            hold_seen  = hold_seq;
            stall_left = HOLD_CYCLES;
         end
         if (steady_left > 0) steady_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (steady_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 3) steady_left = $urandom_range(50, 150);
               else if (r < 25) stall_left = $urandom_range(1, 3);
               else if (r < 28) stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type   sr;
      col_result_type tr;
      int          n_items;
      int          pause_at;
      int          phase;
      bit          burst;
      bit          hot;
      logic [CFG_W-1:0]   bi_raw;
      logic [CFG_W-1:0]   bo_raw;
      logic [VALUE_W-1:0] v;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_COEFF;
      req_ch.coeff_row <= '0;
      req_ch.coeff_col <= '0;
      req_ch.value     <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_BLOCK_IN;
      csr_ch.wdata     <= '0;
      blk_in_reg  = CFG_W'(1);
      blk_out_reg = CFG_W'(1);
      clear_block();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // preload the whole coefficient store so no data item reads an unwritten entry
      for (int r = 0; r < MAX_BLOCK_IN; r++) begin
         for (int c = 0; c < MAX_BLOCK_OUT; c++) begin
            send_item(CMD_COEFF, ROW_W'(r), COL_W'(c), pick_value(), 1'b1);
            idle_gap(1'b0);
         end
      end

      // directed: extremes, rounding, register corner cases, mid-block writes
      directed_rows.push_back(mk_coeff(ROW_W'(0), COL_W'(0), Q_ONE));
      directed_rows.push_back(mk_data_typed(RES_MAX, RES_MAX));
      directed_rows.push_back(mk_data_typed(RES_MIN, RES_MIN));
      directed_rows.push_back(mk_data_typed('0, '0));
      directed_rows.push_back(mk_coeff(ROW_W'(0), COL_W'(0), RES_MAX));
      directed_rows.push_back(mk_data_typed(RES_MAX, RES_MAX));
      directed_rows.push_back(mk_data_typed(RES_MIN, RES_MIN));
      directed_rows.push_back(mk_coeff(ROW_W'(0), COL_W'(0), Q_HALF));
      directed_rows.push_back(mk_data_typed(Q_LSB, Q_LSB));
      directed_rows.push_back(mk_data_typed(Q_MINUS_LSB, '0));
      directed_rows.push_back(mk_coeff('1, '1, RES_MIN));
      directed_rows.push_back(mk_csr(CSR_BLOCK_IN, '0));
      directed_rows.push_back(mk_csr(CSR_BLOCK_OUT, '1));
      directed_rows.push_back(mk_data(32'h0001_2345));
      directed_rows.push_back(mk_csr(CSR_BLOCK_IN, '1));
      directed_rows.push_back(mk_data(RES_MAX));
      directed_rows.push_back(mk_data(RES_MIN));
      directed_rows.push_back(mk_csr(CSR_SPARE_LO, CFG_W'(7)));
      directed_rows.push_back(mk_csr(CSR_SPARE_HI, '0));
      directed_rows.push_back(mk_coeff(ROW_W'(3), COL_W'(5), 32'hDEAD_BEEF));
      directed_rows.push_back(mk_data(Q_ONE));
      directed_rows.push_back(mk_csr(CSR_BLOCK_OUT, CFG_W'(MAX_BLOCK_OUT)));
      directed_rows.push_back(mk_csr(CSR_BLOCK_IN, CFG_W'(2)));
      directed_rows.push_back(mk_data(32'hFFFF_0000));
      directed_rows.push_back(mk_data(32'h4000_0000));
      directed_rows.push_back(mk_csr(CSR_BLOCK_IN, CFG_W'(17)));

      foreach (directed_rows[i]) begin
         sr = directed_rows[i];
         if (sr.kind == ROW_CSR) begin
            write_csr(sr.index, sr.wdata);
         end else begin
            send_item(sr.command, sr.row, sr.col, sr.value, !sr.typed);
            if (sr.typed) begin
               tr.result = sr.want;
               tr.column = '0;
               tr.last   = 1'b1;
               col_results_q.push_back(tr);
            end
            idle_gap(1'b0);
         end
      end

      // random phases: new sizes each phase, data blocks with coefficient updates mixed in
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         hot = (phase > 0) && ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            bi_raw = CFG_W'(1);
            bo_raw = CFG_W'(MAX_BLOCK_OUT);
         end else if (hot) begin
            bi_raw = CFG_W'(5);
            bo_raw = pick_size();
         end else begin
            bi_raw = pick_size();
            bo_raw = pick_size();
         end
         write_csr(CSR_BLOCK_OUT, bo_raw);
         write_csr(CSR_BLOCK_IN, bi_raw);

         // overflow and recovery: column 0 gets max coefficients, data is three max, two min
         if (hot) begin
            for (int r = 0; r < 5; r++) begin
               send_item(CMD_COEFF, ROW_W'(r), '0, RES_MAX, 1'b1);
               random_items++;
               idle_gap(1'b0);
            end
         end

         // first phase: receiver holds off while full blocks keep coming
         if (phase == 0) hold_seq <= hold_seq + 1;

         burst    = (phase == 0) || ($urandom_range(0, 3) == 0);
         n_items  = (phase == 0) ? 40 : $urandom_range(8, 30);
         pause_at = ($urandom_range(0, 2) == 0) ? n_items / 2 : -1;
         for (int k = 0; k < n_items; k++) begin
            if (k == pause_at) wait_drained();
            if (hot) v = (k % 5 < 3) ? RES_MAX : RES_MIN;
            else v = pick_value();
            if (!hot && phase != 0 && $urandom_range(0, 7) == 0) begin
               send_item(CMD_COEFF, ROW_W'($urandom_range(0, 15)),
                         COL_W'($urandom_range(0, 15)), v, 1'b1);
            end else begin
               send_item(CMD_DATA, ROW_W'($urandom_range(0, 15)),
                         COL_W'($urandom_range(0, 15)), v, 1'b1);
            end
            random_items++;
            idle_gap(burst);
         end
         phase++;
      end

      // let everything drain, then a few more cycles for strays
      req_ch.valid <= 1'b0;
      while (col_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_END) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_block_diagonal_matmul_core: done, clean");
      end else begin
         $display("tb_block_diagonal_matmul_core: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/bdm_pkg.sv
rtl/core/bdm_if.sv
rtl/core/bdm_lane.sv
rtl/core/bdm_outq.sv
rtl/core/block_diagonal_matmul_core.sv
dv/tb_block_diagonal_matmul_core.sv
